// ===== rtl/core/tbda_pkg.sv =====
// shared types, constants and helpers for the three-button debounce action unit
package tbda_pkg;

  // width of the wrapping tick counter and all time stamps
  localparam int unsigned TimeWidth = 32;
  localparam int unsigned NumButtons = 3;
  localparam int unsigned NumSteps = 5;

  // button indexes
  localparam int unsigned BtnBright = 0;
  localparam int unsigned BtnMode = 1;
  localparam int unsigned BtnVoice = 2;

  // register indexes on the configuration port
  localparam logic RegDebounce = 1'b0;
  localparam logic RegHold = 1'b1;

  // display mode limits
  localparam logic [2:0] ModeLast = 3'd4;

  // brightness steps in ascending order
  localparam logic [7:0] BrightSteps [NumSteps] = '{8'd8, 8'd16, 8'd32, 8'd64, 8'd102};

  typedef logic [TimeWidth-1:0] tick_t;

  // events a lane found on the current tick
  typedef struct packed {
    logic press;
    logic release_ev;
  } lane_evt_t;

  // first step above the current level, else the lowest step
  function automatic logic [7:0] next_brightness(logic [7:0] cur);
    logic [7:0] res;
    res = BrightSteps[0];
    for (int k = NumSteps - 1; k >= 0; k--) begin
      if (BrightSteps[k] > cur) begin
        res = BrightSteps[k];
      end
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/tbda_lane.sv =====
// per-button debounce qualifier lane
module tbda_lane import tbda_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic       level_i,
  input  tick_t      now_i,
  input  logic [7:0] debounce_polls_i,
  output lane_evt_t  evt_o
);

  logic  raw_last_q, raw_last_d;
  logic  stable_q, stable_d;
  tick_t change_time_q, change_time_d;

  logic  changed;
  logic  qualify;
  tick_t elapsed;

  // level qualification for this tick
  assign changed = level_i != raw_last_q;
  assign elapsed = now_i - change_time_q;
  assign qualify = !changed && (level_i != stable_q) &&
                   (elapsed >= tick_t'(debounce_polls_i));

  assign evt_o.press      = qualify && !level_i;
  assign evt_o.release_ev = qualify && level_i;

  // next state on a transfer
  always_comb begin
    raw_last_d    = raw_last_q;
    stable_d      = stable_q;
    change_time_d = change_time_q;
    if (fire_i) begin
      if (changed) begin
        raw_last_d    = level_i;
        change_time_d = now_i;
      end else if (qualify) begin
        stable_d = level_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_last_q    <= 1'b1;
      stable_q      <= 1'b1;
      change_time_q <= '0;
    end else begin
      raw_last_q    <= raw_last_d;
      stable_q      <= stable_d;
      change_time_q <= change_time_d;
    end
  end

endmodule

// ===== rtl/core/tbda_action.sv =====
// merges lane events into actions and holds the result register
module tbda_action import tbda_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  lane_evt_t  evt_i [NumButtons],
  input  logic [7:0] current_brightness_i,
  input  tick_t      now_i,
  input  logic [15:0] hold_polls_i,
  input  logic       out_stall_i,
  output logic       out_valid_o,
  output logic       brightness_valid_o,
  output logic [7:0] brightness_value_o,
  output logic       mode_valid_o,
  output logic [2:0] mode_number_o,
  output logic       effect_valid_o,
  output logic       effect_number_o,
  output logic       voice_start_o,
  output logic       voice_cancel_o,
  output logic       voice_execute_o
);

  logic [2:0] mode_q, mode_d;
  logic       effect_q, effect_d;
  tick_t      press_time_q, press_time_d;
  logic       out_valid_q, out_valid_d;

  logic       bv_q, mv_q, ev_q, en_q, vs_q, vc_q, vx_q;
  logic [7:0] bval_q;
  logic [2:0] mnum_q;

  tick_t      held;
  logic       short_hold;
  logic [2:0] mode_next;

  assign held       = now_i - press_time_q;
  assign short_hold = held < tick_t'(hold_polls_i);
  assign mode_next  = (mode_q == ModeLast) ? 3'd0 : mode_q + 3'd1;

  // persistent action state
  always_comb begin
    mode_d       = mode_q;
    effect_d     = effect_q;
    press_time_d = press_time_q;
    if (fire_i) begin
      if (evt_i[BtnMode].press) begin
        mode_d = mode_next;
      end
      if (evt_i[BtnVoice].press) begin
        press_time_d = now_i;
      end
      if (evt_i[BtnVoice].release_ev && short_hold) begin
        effect_d = ~effect_q;
      end
    end
  end

  // output register valid: load on transfer in, clear once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (fire_i) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= '0;
      effect_q     <= 1'b0;
      press_time_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      mode_q       <= mode_d;
      effect_q     <= effect_d;
      press_time_q <= press_time_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      bv_q   <= evt_i[BtnBright].press;
      bval_q <= evt_i[BtnBright].press ? next_brightness(current_brightness_i) : 8'd0;
      mv_q   <= evt_i[BtnMode].press;
      mnum_q <= evt_i[BtnMode].press ? mode_next : 3'd0;
      ev_q   <= evt_i[BtnVoice].release_ev && short_hold;
      en_q   <= (evt_i[BtnVoice].release_ev && short_hold) ? ~effect_q : 1'b0;
      vs_q   <= evt_i[BtnVoice].press;
      vc_q   <= evt_i[BtnVoice].release_ev && short_hold;
      vx_q   <= evt_i[BtnVoice].release_ev && !short_hold;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign brightness_valid_o = bv_q;
  assign brightness_value_o = bval_q;
  assign mode_valid_o       = mv_q;
  assign mode_number_o      = mnum_q;
  assign effect_valid_o     = ev_q;
  assign effect_number_o    = en_q;
  assign voice_start_o      = vs_q;
  assign voice_cancel_o     = vc_q;
  assign voice_execute_o    = vx_q;

endmodule

// ===== rtl/core/three_button_debounce_action_unit.sv =====
// top level of the three-button debounce action unit
//
// One input transfer is one poll tick: three raw active-low button levels
// and the brightness now on the display. Each tick gives exactly one result
// transfer with brightness, mode, effect and voice action fields.
// Both channels use valid/stall; a transfer happens when valid is high and
// stall is low. The result of a tick sits in
// the output register the cycle after its transfer in.
// Throughput is one tick per cycle while the receiver takes results; the output register is loaded while
// the previous result is taken, so ticks stream back to back.
// When the receiver stalls with a result waiting, in_stall_o rises and no
// new tick is taken until that result leaves.
// The three buttons run in parallel debounce lanes; a merge stage turns
// their press/release events into actions.
// Registers on the APB port: debounce_polls at 0x0, hold_polls at 0x4.
// Write them only while the block is idle.
// Reset puts all buttons released, tick counter, mode and effect at zero,
// and the registers at 3 and 25. No clearing pass is needed.
module three_button_debounce_action_unit import tbda_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tick channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        button0_level_i,
  input  logic        button1_level_i,
  input  logic        button2_level_i,
  input  logic [7:0]  current_brightness_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        brightness_valid_o,
  output logic [7:0]  brightness_value_o,
  output logic        mode_valid_o,
  output logic [2:0]  mode_number_o,
  output logic        effect_valid_o,
  output logic        effect_number_o,
  output logic        voice_start_o,
  output logic        voice_cancel_o,
  output logic        voice_execute_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        fire;
  logic        out_valid;
  tick_t       tick_q, tick_d;
  logic [7:0]  debounce_q, debounce_d;
  logic [15:0] hold_q, hold_d;
  logic        cfg_wr;
  logic        levels [NumButtons];
  lane_evt_t   evts [NumButtons];

  // input handshake
  assign in_stall_o = out_valid && out_stall_i;
  assign fire       = in_valid_i && !in_stall_o;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    debounce_d = debounce_q;
    hold_d     = hold_q;
    if (cfg_wr) begin
      unique case (paddr[2])
        RegDebounce: debounce_d = pwdata[7:0];
        RegHold:     hold_d     = pwdata[15:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegDebounce: prdata = {24'd0, debounce_q};
      RegHold:     prdata = {16'd0, hold_q};
      default:     prdata = '0;
    endcase
  end

  // tick counter advances once per tick transfer
  assign tick_d = fire ? tick_q + tick_t'(1) : tick_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q     <= '0;
      debounce_q <= 8'd3;
      hold_q     <= 16'd25;
    end else begin
      tick_q     <= tick_d;
      debounce_q <= debounce_d;
      hold_q     <= hold_d;
    end
  end

  // debounce lanes
  assign levels[BtnBright] = button0_level_i;
  assign levels[BtnMode]   = button1_level_i;
  assign levels[BtnVoice]  = button2_level_i;

  for (genvar g = 0; g < NumButtons; g++) begin : g_lane
    tbda_lane u_lane (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .fire_i          (fire),
      .level_i         (levels[g]),
      .now_i           (tick_q),
      .debounce_polls_i(debounce_q),
      .evt_o           (evts[g])
    );
  end

  // merge stage and result register
  tbda_action u_action (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .fire_i              (fire),
    .evt_i               (evts),
    .current_brightness_i(current_brightness_i),
    .now_i               (tick_q),
    .hold_polls_i        (hold_q),
    .out_stall_i         (out_stall_i),
    .out_valid_o         (out_valid),
    .brightness_valid_o  (brightness_valid_o),
    .brightness_value_o  (brightness_value_o),
    .mode_valid_o        (mode_valid_o),
    .mode_number_o       (mode_number_o),
    .effect_valid_o      (effect_valid_o),
    .effect_number_o     (effect_number_o),
    .voice_start_o       (voice_start_o),
    .voice_cancel_o      (voice_cancel_o),
    .voice_execute_o     (voice_execute_o)
  );

  assign out_valid_o = out_valid;

endmodule

// ===== tb/sv/three_button_debounce_action_unit_tb.sv =====
// self-checking testbench for the three-button debounce action unit
`timescale 1ns / 1ps

module three_button_debounce_action_unit_tb;
  import tbda_pkg::*;

  // one poll tick: lvl[k] is the raw level of button k, 0 pressed
  typedef struct packed {
    logic [2:0] lvl;
    logic [7:0] cur;
  } poll_t;

  // actions reported for one tick
  typedef struct packed {
    logic       bright_vld;
    logic [7:0] bright_val;
    logic       mode_vld;
    logic [2:0] mode_num;
    logic       fx_vld;
    logic       fx_num;
    logic       v_start;
    logic       v_cancel;
    logic       v_exec;
  } action_t;

  typedef struct packed {
    poll_t   poll;
    logic    typed;
    action_t act;
  } dir_row_t;

  typedef struct packed {
    int dbc;
    int hold;
    int send_pct;
    int recv_pct;
    int items;
  } phase_t;

  localparam action_t NoAct = '0;
  localparam int NumRows = 21;

  // directed ticks, run with debounce 0 and hold 4; levels written b2 b1 b0
  // buttons 0 and 1 press every fourth tick, so brightness walks the steps
  // and the mode index wraps; button 2 gives an execute right at the hold
  // limit, a cancel one tick short of it, a bounce, and a second cancel
  localparam dir_row_t DirRows [NumRows] = '{
    '{'{3'b111, 8'd0},   1'b1, NoAct},
    '{'{3'b000, 8'd200}, 1'b0, NoAct},
    '{'{3'b000, 8'd0},   1'b1,
      '{1'b1, 8'd8, 1'b1, 3'd1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0}},
    '{'{3'b011, 8'd77},  1'b0, NoAct},
    '{'{3'b011, 8'd15},  1'b0, NoAct},
    '{'{3'b100, 8'd31},  1'b0, NoAct},
    '{'{3'b100, 8'd8},   1'b0, NoAct},
    '{'{3'b011, 8'd63},  1'b0, NoAct},
    '{'{3'b011, 8'd64},  1'b0, NoAct},
    '{'{3'b000, 8'd130}, 1'b0, NoAct},
    '{'{3'b100, 8'd101}, 1'b0, NoAct},
    '{'{3'b111, 8'd16},  1'b0, NoAct},
    '{'{3'b011, 8'd32},  1'b0, NoAct},
    '{'{3'b100, 8'd250}, 1'b0, NoAct},
    '{'{3'b100, 8'd102}, 1'b0, NoAct},
    '{'{3'b011, 8'd1},   1'b0, NoAct},
    '{'{3'b011, 8'd99},  1'b0, NoAct},
    '{'{3'b100, 8'd128}, 1'b0, NoAct},
    '{'{3'b100, 8'd255}, 1'b1,
      '{1'b1, 8'd8, 1'b1, 3'd0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0}},
    '{'{3'b111, 8'd170}, 1'b0, NoAct},
    '{'{3'b111, 8'd85},  1'b0, NoAct}
  };

  // register settings and idling per random phase
  localparam phase_t Phases [6] = '{
    '{0,   1,     0,  0,  80},
    '{5,   20,    56, 0,  80},
    '{2,   65535, 0,  56, 80},
    '{1,   12,    9,  9,  80},
    '{255, 300,   0,  0,  50},
    '{3,   25,    9,  9,  60}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  btn_lvl = 3'b111;
  logic [7:0]  cur_bright = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        bright_vld;
  logic [7:0]  bright_val;
  logic        mode_vld;
  logic [2:0]  mode_num;
  logic        fx_vld;
  logic        fx_num;
  logic        v_start;
  logic        v_cancel;
  logic        v_exec;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // expected value travels with the tick on directed rows that carry one
  logic        row_typed = 1'b0;
  action_t     row_act = '0;

  int send_pct = 0;
  int recv_pct = 0;
  int sent_cnt = 0;
  int checked_cnt = 0;
  int fail_cnt = 0;

  action_t pending_actions [$];

  // predictor state and register mirror
  logic [7:0]  dbc_reg = 8'd3;
  logic [15:0] hold_reg = 16'd25;
  tick_t       tick_cnt = '0;
  logic [2:0]  raw_last = 3'b111;
  logic [2:0]  stable = 3'b111;
  tick_t       chg_time [3] = '{'0, '0, '0};
  tick_t       press_t = '0;
  logic [2:0]  mode_idx = '0;
  logic        fx_idx = 1'b0;

  // random level generator state
  logic [2:0]  gen_lvl = 3'b111;
  int          gen_left [3] = '{0, 0, 0};

  three_button_debounce_action_unit dut (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .in_valid_i           (in_valid),
    .in_stall_o           (in_stall),
    .button0_level_i      (btn_lvl[0]),
    .button1_level_i      (btn_lvl[1]),
    .button2_level_i      (btn_lvl[2]),
    .current_brightness_i (cur_bright),
    .out_valid_o          (out_valid),
    .out_stall_i          (out_stall),
    .brightness_valid_o   (bright_vld),
    .brightness_value_o   (bright_val),
    .mode_valid_o         (mode_vld),
    .mode_number_o        (mode_num),
    .effect_valid_o       (fx_vld),
    .effect_number_o      (fx_num),
    .voice_start_o        (v_start),
    .voice_cancel_o       (v_cancel),
    .voice_execute_o      (v_exec),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stall
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_pct);
  end

  // first brightness step above the current level, wrapping to the lowest
  function automatic logic [7:0] step_above(logic [7:0] cur);
    if (cur < 8'd8) return 8'd8;
    else if (cur < 8'd16) return 8'd16;
    else if (cur < 8'd32) return 8'd32;
    else if (cur < 8'd64) return 8'd64;
    else if (cur < 8'd102) return 8'd102;
    return 8'd8;
  endfunction

  // advance the debounce lanes by one tick and return its actions
  function automatic action_t debounce_tick(poll_t p);
    action_t a;
    tick_t   now;
    tick_t   gap;
    a = '0;
    now = tick_cnt;
    for (int k = 0; k < NumButtons; k++) begin
      gap = now - chg_time[k];
      if (p.lvl[k] != raw_last[k]) begin
        raw_last[k] = p.lvl[k];
        chg_time[k] = now;
      end else if (p.lvl[k] != stable[k] && gap >= tick_t'(dbc_reg)) begin
        stable[k] = p.lvl[k];
        if (!p.lvl[k]) begin
          if (k == BtnBright) begin
            a.bright_vld = 1'b1;
            a.bright_val = step_above(p.cur);
          end else if (k == BtnMode) begin
            mode_idx = (mode_idx == ModeLast) ? 3'd0 : mode_idx + 3'd1;
            a.mode_vld = 1'b1;
            a.mode_num = mode_idx;
          end else begin
            press_t = now;
            a.v_start = 1'b1;
          end
        end else if (k == BtnVoice) begin
          // short hold cancels and flips the effect, long hold executes
          gap = now - press_t;
          if (gap < tick_t'(hold_reg)) begin
            a.v_cancel = 1'b1;
            fx_idx = ~fx_idx;
            a.fx_vld = 1'b1;
            a.fx_num = fx_idx;
          end else begin
            a.v_exec = 1'b1;
          end
        end
      end
    end
    tick_cnt = tick_cnt + 1'b1;
    return a;
  endfunction

  function automatic void cmp_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_cnt++;
    end
  endfunction

  // predict on each input transfer, check each result transfer
  always @(posedge clk) begin : watch
    action_t got;
    action_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        want = debounce_tick('{btn_lvl, cur_bright});
        pending_actions.push_back(row_typed ? row_act : want);
      end
      if (out_valid && !out_stall) begin
        checked_cnt++;
        got = '{bright_vld, bright_val, mode_vld, mode_num, fx_vld, fx_num,
                v_start, v_cancel, v_exec};
        if (pending_actions.size() == 0) begin
          $error("result transfer with no tick waiting");
          fail_cnt++;
        end else begin
          want = pending_actions.pop_front();
          cmp_field("brightness_valid", want.bright_vld, got.bright_vld);
          cmp_field("brightness_value", want.bright_val, got.bright_val);
          cmp_field("mode_valid", want.mode_vld, got.mode_vld);
          cmp_field("mode_number", want.mode_num, got.mode_num);
          cmp_field("effect_valid", want.fx_vld, got.fx_vld);
          cmp_field("effect_number", want.fx_num, got.fx_num);
          cmp_field("voice_start", want.v_start, got.v_start);
          cmp_field("voice_cancel", want.v_cancel, got.v_cancel);
          cmp_field("voice_execute", want.v_exec, got.v_exec);
        end
      end
    end
  end

  // brightness biased toward the step boundaries
  function automatic logic [7:0] pick_bright();
    case ($urandom_range(0, 15))
      0: return 8'd0;
      1: return 8'd7;
      2: return 8'd8;
      3: return 8'd15;
      4: return 8'd16;
      5: return 8'd31;
      6: return 8'd32;
      7: return 8'd63;
      8: return 8'd64;
      9: return 8'd101;
      10: return 8'd102;
      11: return 8'd103;
      12: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // press/release runs per button with random lengths, short glitches
  // and single-tick noise on top
  function automatic poll_t next_poll();
    poll_t p;
    int    hc;
    hc = (hold_reg > 16'd60) ? 60 : int'(hold_reg);
    for (int k = 0; k < NumButtons; k++) begin
      if (gen_left[k] == 0) begin
        gen_lvl[k] = ~gen_lvl[k];
        if ($urandom_range(99) < 15)
          gen_left[k] = $urandom_range(1, 3);
        else if (k == BtnVoice && !gen_lvl[k])
          gen_left[k] = int'(dbc_reg) + 1 + $urandom_range(0, 2 * hc);
        else
          gen_left[k] = int'(dbc_reg) + 1 + $urandom_range(0, 8);
      end
      gen_left[k]--;
    end
    p.lvl = gen_lvl;
    if ($urandom_range(99) < 8) p.lvl[$urandom_range(0, 2)] ^= 1'b1;
    p.cur = pick_bright();
    return p;
  endfunction

  // one tick transfer, with random idle cycles ahead of it
  task automatic send_poll(input poll_t p, input logic typed, input action_t a);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    btn_lvl    <= p.lvl;
    cur_bright <= p.cur;
    row_typed  <= typed;
    row_act    <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_cnt++;
  endtask

  // apb write, or read compared against data
  task automatic cfg_access(input logic wr, input logic idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wr ? data : 32'd0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (!wr && prdata !== data) begin
      $error("prdata of register %0d: expected %0d, got %0d", idx, data, prdata);
      fail_cnt++;
    end
    if (wr) begin
      if (idx == RegDebounce) dbc_reg = data[7:0];
      else hold_reg = data[15:0];
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (checked_cnt < sent_cnt) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input int dbc, input int hold);
    wait_idle();
    cfg_access(1'b1, RegDebounce, dbc);
    cfg_access(1'b0, RegDebounce, dbc);
    cfg_access(1'b1, RegHold, hold);
    cfg_access(1'b0, RegHold, hold);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register values after reset
    cfg_access(1'b0, RegDebounce, 32'd3);
    cfg_access(1'b0, RegHold, 32'd25);

    // directed ticks
    set_config(0, 4);
    for (int i = 0; i < NumRows; i++) begin
      send_poll(DirRows[i].poll, DirRows[i].typed, DirRows[i].act);
    end

    // random phases
    for (int ph = 0; ph < 6; ph++) begin
      set_config(Phases[ph].dbc, Phases[ph].hold);
      send_pct = Phases[ph].send_pct;
      recv_pct = Phases[ph].recv_pct;
      repeat (Phases[ph].items) send_poll(next_poll(), 1'b0, NoAct);
    end

    wait_idle();
    if (pending_actions.size() != 0) begin
      $error("%0d expected results never arrived", pending_actions.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
